[rtl/kway_merge_sample_count_filter_macros.svh]
// Assertion macros for the k-way merge RTL.
// Depends on nothing; included by kmsc_scan, the module that carries checks.
`ifndef KWAY_MERGE_SAMPLE_COUNT_FILTER_MACROS_SVH
`define KWAY_MERGE_SAMPLE_COUNT_FILTER_MACROS_SVH

// same-cycle implication
`define KMSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmsc assertion failed");

// next-cycle implication
`define KMSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmsc assertion failed");

`endif

[rtl/kmsc_pkg.sv]
// Package for the k-way merge block: constants, codes, types, width helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmsc_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int KEY_BITS_DEF    = 64;

    localparam int SAMPLE_W   = 6;
    localparam int IN_KEY_W   = 64;
    localparam int IN_COUNT_W = 32;
    localparam int OUT_KEY_W  = 64;
    localparam int MULT_W     = 16;
    localparam int CFG_W      = 7;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 88;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    localparam logic REG_SAMPLES_IN_USE = 1'b0;
    localparam logic REG_KEEP_THRESH    = 1'b1;

    localparam logic [CFG_W-1:0] SAMPLES_IN_USE_RST = 7'd16;
    localparam logic [CFG_W-1:0] KEEP_THRESH_RST    = 7'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OUT_KEY_W-1:0] min_key;
        logic [SAMPLE_W-1:0]  sample_index;
        logic [MULT_W-1:0]    multiplicity;
        logic                 advance;
        logic                 kept;
        logic                 last;
        logic                 done_res;
    } res_t;

    function automatic int idx_w(input int m);
        return (m > 1) ? $clog2(m) : 1;
    endfunction

    function automatic int cnt_w(input int m);
        return $clog2(m + 1);
    endfunction

endpackage

`default_nettype wire

[rtl/kway_merge_sample_count_filter.sv]
// Top level of the k-way merge with per-sample counts and sample-count filter.
// Depends on kmsc_pkg, kmsc_head_mem, kmsc_scan, kmsc_out_reg.
//
// channel   side     handshake                    payload
// s_axis    in       s_axis_tvalid/s_axis_tready  tdata, tuser = op
// m_axis    out      m_axis_tvalid/m_axis_tready  tdata, tuser = done_res, tlast
// apb       config   psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// A merge step over n streams in use makes one head memory read per cycle for the
// minimum scan, then, if a minimum was found, one read per cycle for the result
// pass. A stalled output holds the result pass; no new transaction is accepted
// until the step's last result is in the output register.
// Reset clears the head valid bits and restores the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module kway_merge_sample_count_filter #(
    parameter int MAX_SAMPLES = kmsc_pkg::MAX_SAMPLES_DEF,
    parameter int KEY_BITS    = kmsc_pkg::KEY_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample[5:0], key[69:6], count[101:70], present[102], zero pad[103]
    input  wire logic [kmsc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // min_key[63:0], sample_index[69:64], multiplicity[85:70], advance[86], kept[87]
    output logic      [kmsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // done_res
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kmsc_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [kmsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [kmsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import kmsc_pkg::*;

    localparam int IDX_W = idx_w(MAX_SAMPLES);

    logic [CFG_W-1:0] samples_in_use_reg;
    logic [CFG_W-1:0] keep_thresh_reg;
    logic             cfg_wr;

    logic                in_op;
    logic [SAMPLE_W-1:0] in_sample;
    logic [IN_KEY_W-1:0] in_key;
    logic [IN_COUNT_W-1:0] in_count;
    logic                in_present;

    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    logic [KEY_BITS-1:0] mem_wr_key;
    logic [MULT_W-1:0]   mem_wr_count;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [KEY_BITS-1:0] mem_rd_key;
    logic [MULT_W-1:0]   mem_rd_count;

    logic out_free;
    logic res_load;
    res_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_in_use_reg <= SAMPLES_IN_USE_RST;
            keep_thresh_reg    <= KEEP_THRESH_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SAMPLES_IN_USE)
            begin
                samples_in_use_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                keep_thresh_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_KEEP_THRESH)
        begin
            prdata = APB_DATA_W'(keep_thresh_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(samples_in_use_reg);
        end
    end

    assign in_op      = s_axis_tuser;
    assign in_sample  = s_axis_tdata[5:0];
    assign in_key     = s_axis_tdata[69:6];
    assign in_count   = s_axis_tdata[101:70];
    assign in_present = s_axis_tdata[102];

    kmsc_head_mem #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .KEY_BITS    (KEY_BITS)
    ) u_head_mem (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_key   (mem_wr_key),
        .wr_count (mem_wr_count),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_key   (mem_rd_key),
        .rd_count (mem_rd_count)
    );

    kmsc_scan #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .KEY_BITS    (KEY_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_op          (in_op),
        .in_sample      (in_sample),
        .in_key         (in_key),
        .in_count       (in_count),
        .in_present     (in_present),
        .samples_in_use (samples_in_use_reg),
        .keep_thresh    (keep_thresh_reg),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_key     (mem_wr_key),
        .mem_wr_count   (mem_wr_count),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_key     (mem_rd_key),
        .mem_rd_count   (mem_rd_count),
        .out_free       (out_free),
        .res_load       (res_load),
        .res            (res)
    );

    kmsc_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_load      (res_load),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[rtl/kmsc_head_mem.sv]
// Head record memory: key and low count bits per stream, one write and one read port.
// Depends on kmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmsc_head_mem #(
    parameter int MAX_SAMPLES = kmsc_pkg::MAX_SAMPLES_DEF,
    parameter int KEY_BITS    = kmsc_pkg::KEY_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [kmsc_pkg::idx_w(MAX_SAMPLES)-1:0]  wr_addr,
    input  wire logic [KEY_BITS-1:0]                      wr_key,
    input  wire logic [kmsc_pkg::MULT_W-1:0]              wr_count,
    input  wire logic                                     rd_en,
    input  wire logic [kmsc_pkg::idx_w(MAX_SAMPLES)-1:0]  rd_addr,
    output logic      [KEY_BITS-1:0]                      rd_key,
    output logic      [kmsc_pkg::MULT_W-1:0]              rd_count
);
    import kmsc_pkg::*;

    localparam int ENTRY_W = KEY_BITS + MULT_W;

    logic [ENTRY_W-1:0] mem [MAX_SAMPLES];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_count};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key   = rd_data_reg[ENTRY_W-1:MULT_W];
    assign rd_count = rd_data_reg[MULT_W-1:0];

endmodule

`default_nettype wire

[rtl/kmsc_scan.sv]
// Merge sequencer: load handling, valid bits, minimum scan and per-stream emit pass.
// Depends on kmsc_pkg and kway_merge_sample_count_filter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "kway_merge_sample_count_filter_macros.svh"

module kmsc_scan #(
    parameter int MAX_SAMPLES = kmsc_pkg::MAX_SAMPLES_DEF,
    parameter int KEY_BITS    = kmsc_pkg::KEY_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic                                     in_op,
    input  wire logic [kmsc_pkg::SAMPLE_W-1:0]            in_sample,
    input  wire logic [kmsc_pkg::IN_KEY_W-1:0]            in_key,
    input  wire logic [kmsc_pkg::IN_COUNT_W-1:0]          in_count,
    input  wire logic                                     in_present,
    input  wire logic [kmsc_pkg::CFG_W-1:0]               samples_in_use,
    input  wire logic [kmsc_pkg::CFG_W-1:0]               keep_thresh,
    output logic                                          mem_wr_en,
    output logic      [kmsc_pkg::idx_w(MAX_SAMPLES)-1:0]  mem_wr_addr,
    output logic      [KEY_BITS-1:0]                      mem_wr_key,
    output logic      [kmsc_pkg::MULT_W-1:0]              mem_wr_count,
    output logic                                          mem_rd_en,
    output logic      [kmsc_pkg::idx_w(MAX_SAMPLES)-1:0]  mem_rd_addr,
    input  wire logic [KEY_BITS-1:0]                      mem_rd_key,
    input  wire logic [kmsc_pkg::MULT_W-1:0]              mem_rd_count,
    input  wire logic                                     out_free,
    output logic                                          res_load,
    output kmsc_pkg::res_t                                res
);
    import kmsc_pkg::*;

    localparam int IDX_W = idx_w(MAX_SAMPLES);
    localparam int CNT_W = cnt_w(MAX_SAMPLES);
    localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   d_vld_reg, d_vld_next;
    logic [IDX_W-1:0]       d_idx_reg, d_idx_next;
    logic [KEY_BITS-1:0]    mk_reg, mk_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [MAX_SAMPLES-1:0] valid_reg;

    logic [CNT_W-1:0] n_used;
    logic             in_accept;
    logic             load_ok;
    logic             issue_more;
    logic             scan_end;
    logic             cur_valid;
    logic             cur_hit;
    logic             d_last;
    logic             kept;

    always_comb
    begin
        if (samples_in_use == '0)
        begin
            n_used = CNT_W'(1);
        end
        else if (samples_in_use > MAX_CFG)
        begin
            n_used = MAX_CNT;
        end
        else
        begin
            n_used = samples_in_use[CNT_W-1:0];
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign load_ok    = in_accept && (in_op == OP_LOAD) && ({1'b0, in_sample} < MAX_CFG);
    assign issue_more = (rd_cnt_reg < n_used);
    assign scan_end   = !issue_more && !d_vld_reg;
    assign cur_valid  = valid_reg[d_idx_reg];
    assign cur_hit    = cur_valid && (mem_rd_key == mk_reg);
    assign d_last     = (CNT_W'(d_idx_reg) == (n_used - CNT_W'(1)));
    assign kept       = (CFG_W'(hit_cnt_reg) >= keep_thresh);

    assign mem_wr_en    = load_ok;
    assign mem_wr_addr  = in_sample[IDX_W-1:0];
    assign mem_wr_key   = in_key[KEY_BITS-1:0];
    assign mem_wr_count = in_count[MULT_W-1:0];
    assign mem_rd_addr  = rd_cnt_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_op == OP_MERGE))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = found_reg ? ST_EMIT : ST_DONE;
                end
            end
            ST_EMIT:
            begin
                if (res_load && d_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        mem_rd_en = 1'b0;
        res_load  = 1'b0;
        res       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                mem_rd_en = issue_more;
            end
            ST_EMIT:
            begin
                res_load         = d_vld_reg && out_free;
                mem_rd_en        = issue_more && (!d_vld_reg || res_load);
                res.min_key      = OUT_KEY_W'(mk_reg);
                res.sample_index = SAMPLE_W'(d_idx_reg);
                res.multiplicity = cur_hit ? mem_rd_count : '0;
                res.advance      = cur_hit;
                res.kept         = kept;
                res.last         = d_last;
            end
            ST_DONE:
            begin
                res_load     = out_free;
                res.last     = 1'b1;
                res.done_res = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // scan datapath
    always_comb
    begin
        rd_cnt_next  = rd_cnt_reg;
        d_vld_next   = d_vld_reg;
        d_idx_next   = d_idx_reg;
        mk_next      = mk_reg;
        found_next   = found_reg;
        hit_cnt_next = hit_cnt_reg;

        if (in_accept && (in_op == OP_MERGE))
        begin
            rd_cnt_next  = '0;
            d_vld_next   = 1'b0;
            found_next   = 1'b0;
            hit_cnt_next = '0;
        end

        if (mem_rd_en)
        begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
            d_idx_next  = mem_rd_addr;
        end

        if (state_reg == ST_SCAN)
        begin
            d_vld_next = mem_rd_en;
            if (d_vld_reg && cur_valid)
            begin
                if (!found_reg || (mem_rd_key < mk_reg))
                begin
                    mk_next      = mem_rd_key;
                    found_next   = 1'b1;
                    hit_cnt_next = CNT_W'(1);
                end
                else if (mem_rd_key == mk_reg)
                begin
                    hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                end
            end
            if (scan_end)
            begin
                rd_cnt_next = '0;
            end
        end
        else if (state_reg == ST_EMIT)
        begin
            d_vld_next = mem_rd_en || (d_vld_reg && !res_load);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            d_vld_reg   <= 1'b0;
            found_reg   <= 1'b0;
            hit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            d_vld_reg   <= d_vld_next;
            found_reg   <= found_next;
            hit_cnt_reg <= hit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_idx_reg <= d_idx_next;
        mk_reg    <= mk_next;
    end

    // head valid bits; matched heads drop out as their result is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load_ok)
        begin
            valid_reg[in_sample[IDX_W-1:0]] <= in_present;
        end
        else if ((state_reg == ST_EMIT) && res_load && cur_hit)
        begin
            valid_reg[d_idx_reg] <= 1'b0;
        end
    end

    `KMSC_ASSERT_NXT(a_last_to_idle, clk, rst_n, res_load && res.last, state_reg == ST_IDLE)
    `KMSC_ASSERT_IMP(a_cnt_range, clk, rst_n, state_reg != ST_IDLE, rd_cnt_reg <= n_used)
    `KMSC_ASSERT_IMP(a_emit_found, clk, rst_n, state_reg == ST_EMIT, found_reg)
    `KMSC_ASSERT_IMP(a_done_empty, clk, rst_n, state_reg == ST_DONE, !found_reg)

endmodule

`default_nettype wire

[rtl/kmsc_out_reg.sv]
// Output register for result transactions on the master-side stream.
// Depends on kmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmsc_out_reg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              res_load,
    input  wire kmsc_pkg::res_t                    res,
    output logic                                   out_free,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [kmsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import kmsc_pkg::*;

    logic valid_reg;
    res_t data_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.kept, data_reg.advance, data_reg.multiplicity,
                            data_reg.sample_index, data_reg.min_key};
    assign m_axis_tuser  = data_reg.done_res;
    assign m_axis_tlast  = data_reg.last;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for kway_merge_sample_count_filter: loads stream heads, runs
// merge steps under random stalls and register settings, checks every result transaction.
// Depends on kmsc_pkg and the kway_merge_sample_count_filter RTL.
`timescale 1ns / 1ps

module tb_top;

    import kmsc_pkg::*;

    class merge_checker;
        logic [IN_KEY_W-1:0]   head_key [MAX_SAMPLES_DEF];
        logic [IN_COUNT_W-1:0] head_count [MAX_SAMPLES_DEF];
        bit                    head_valid [MAX_SAMPLES_DEF];
        bit [CFG_W-1:0]        streams_reg;
        bit [CFG_W-1:0]        threshold_reg;
        res_t                  pending_results[$];
        int                    errors;

        function new();
            foreach (head_valid[i])
            begin
                head_key[i]   = '0;
                head_count[i] = '0;
                head_valid[i] = 1'b0;
            end
            streams_reg   = SAMPLES_IN_USE_RST;
            threshold_reg = KEEP_THRESH_RST;
            errors        = 0;
        endfunction

        function int streams_merged();
            if (streams_reg == 0)
                return 1;
            if (streams_reg > MAX_SAMPLES_DEF)
                return MAX_SAMPLES_DEF;
            return int'(streams_reg);
        endfunction

        function void set_register(logic idx, bit [CFG_W-1:0] value);
            if (idx == REG_SAMPLES_IN_USE)
                streams_reg = value;
            else
                threshold_reg = value;
        endfunction

        function void note_record(logic op, logic [SAMPLE_W-1:0] smp, logic [IN_KEY_W-1:0] key,
                                  logic [IN_COUNT_W-1:0] count, logic present);
            int                   n;
            int                   hit_total;
            bit                   found;
            bit                   hit;
            logic [IN_KEY_W-1:0]  low_key;
            res_t                 r;
            if (op == OP_LOAD)
            begin
                head_key[smp]   = key;
                head_count[smp] = count;
                head_valid[smp] = present;
                return;
            end
            n         = streams_merged();
            hit_total = 0;
            found     = 1'b0;
            low_key   = '0;
            for (int i = 0; i < n; i++)
            begin
                if (!head_valid[i])
                    continue;
                if (!found || head_key[i] < low_key)
                begin
                    low_key   = head_key[i];
                    found     = 1'b1;
                    hit_total = 0;
                end
                if (head_key[i] == low_key)
                    hit_total++;
            end
            if (!found)
            begin
                r          = '0;
                r.last     = 1'b1;
                r.done_res = 1'b1;
                pending_results.insert(pending_results.size(), r);
                return;
            end
            for (int i = 0; i < n; i++)
            begin
                hit            = head_valid[i] && head_key[i] == low_key;
                r.min_key      = low_key;
                r.sample_index = SAMPLE_W'(i);
                r.multiplicity = hit ? head_count[i][MULT_W-1:0] : '0;
                r.advance      = hit;
                r.kept         = hit_total >= int'(threshold_reg);
                r.last         = (i == n - 1);
                r.done_res     = 1'b0;
                pending_results.insert(pending_results.size(), r);
                if (hit)
                    head_valid[i] = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: key %0h sample %0d", got.min_key,
                       got.sample_index);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("min_key", want.min_key, got.min_key);
            compare_field("sample_index", 64'(want.sample_index), 64'(got.sample_index));
            compare_field("multiplicity", 64'(want.multiplicity), 64'(got.multiplicity));
            compare_field("advance", 64'(want.advance), 64'(got.advance));
            compare_field("kept", 64'(want.kept), 64'(got.kept));
            compare_field("last", 64'(want.last), 64'(got.last));
            compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    merge_checker merge_sb = new();
    int           records_sent = 0;
    int           calm_after = 1 << 30;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;

    kway_merge_sample_count_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    initial
    begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    // output side: random back-pressure, one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.min_key      = m_axis_tdata[63:0];
            got.sample_index = m_axis_tdata[69:64];
            got.multiplicity = m_axis_tdata[85:70];
            got.advance      = m_axis_tdata[86];
            got.kept         = m_axis_tdata[87];
            got.last         = m_axis_tlast;
            got.done_res     = m_axis_tuser;
            merge_sb.check_result(got);
        end
    end

    task automatic send_record(input logic op, input logic [SAMPLE_W-1:0] smp,
                               input logic [IN_KEY_W-1:0] key,
                               input logic [IN_COUNT_W-1:0] count, input logic present);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, present, count, key, smp};
        do @(posedge clk); while (!s_axis_tready);
        merge_sb.note_record(op, smp, key, count, present);
        records_sent++;
        if (records_sent >= calm_after)
            calm = 1'b1;
    endtask

    task automatic load_head(input int smp, input logic [IN_KEY_W-1:0] key,
                             input logic [IN_COUNT_W-1:0] count, input logic present);
        send_record(OP_LOAD, SAMPLE_W'(smp), key, count, present);
    endtask

    task automatic merge_step();
        send_record(OP_MERGE, SAMPLE_W'($urandom), {$urandom, $urandom}, $urandom,
                    1'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (merge_sb.pending_results.size() != 0);
    endtask

    // registers change only with the block idle
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        drain();
        repeat (2 * MAX_SAMPLES_DEF + 12) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        merge_sb.set_register(idx, value);
    endtask

    initial
    begin
        int                  rand_start;
        int                  phase;
        int                  steps;
        int                  n_eff;
        bit                  live;
        bit [CFG_W-1:0]      cfg_n;
        bit [CFG_W-1:0]      cfg_min;
        logic [IN_KEY_W-1:0] base;
        int                  remaining [MAX_SAMPLES_DEF];
        logic [IN_KEY_W-1:0] next_key [MAX_SAMPLES_DEF];
        bit                  ended [MAX_SAMPLES_DEF];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every head written once, all share one key: full match at the top threshold
        write_reg(REG_SAMPLES_IN_USE, 7'd64);
        write_reg(REG_KEEP_THRESH, 7'd64);
        base = {$urandom, $urandom};
        for (int i = 0; i < MAX_SAMPLES_DEF; i++)
            load_head(i, base, $urandom, 1'b1);
        merge_step();

        write_reg(REG_SAMPLES_IN_USE, SAMPLES_IN_USE_RST);
        write_reg(REG_KEEP_THRESH, KEEP_THRESH_RST);
        merge_step();
        load_head(0, '1, '1, 1'b1);
        load_head(1, '0, '0, 1'b1);
        load_head(2, '0, 32'hABCD_1234, 1'b1);
        load_head(3, 64'd5, 32'd7, 1'b0);
        load_head(63, '0, 32'd1, 1'b1);
        merge_step();
        merge_step();
        merge_step();

        // stream count of zero behaves as one
        write_reg(REG_SAMPLES_IN_USE, 7'd0);
        load_head(0, 64'hAAAA_5555_AAAA_5555, 32'h8000_FFFF, 1'b1);
        merge_step();

        // oversized stream count clamps to the maximum; zero threshold keeps all
        write_reg(REG_SAMPLES_IN_USE, 7'd127);
        write_reg(REG_KEEP_THRESH, 7'd0);
        merge_step();
        load_head(10, 64'h8000_0000_0000_0000, 32'h0001_0000, 1'b1);
        load_head(20, 64'h8000_0000_0000_0000, 32'hFFFF_0001, 1'b1);
        write_reg(REG_KEEP_THRESH, 7'd127);
        merge_step();
        merge_step();

        rand_start = records_sent;
        calm_after = rand_start + 100;
        phase      = 0;
        while (records_sent < rand_start + 120)
        begin
            case ($urandom_range(0, 5))
                0: cfg_n = 7'd0;
                1: cfg_n = 7'd1;
                default: cfg_n = CFG_W'($urandom_range(2, 12));
            endcase
            n_eff = (cfg_n == 0) ? 1 : int'(cfg_n);
            case ($urandom_range(0, 6))
                0: cfg_min = 7'd0;
                1: cfg_min = 7'd1;
                2: cfg_min = 7'd2;
                3: cfg_min = CFG_W'(n_eff);
                4: cfg_min = CFG_W'(n_eff + 1);
                5: cfg_min = 7'd127;
                default: cfg_min = CFG_W'($urandom_range(0, n_eff));
            endcase
            write_reg(REG_SAMPLES_IN_USE, cfg_n);
            write_reg(REG_KEEP_THRESH, cfg_min);
            if (phase == 1)
                hold_req = 1'b1;

            base = {$urandom, $urandom};
            for (int i = 0; i < n_eff; i++)
            begin
                remaining[i] = $urandom_range(0, 4);
                next_key[i]  = base + $urandom_range(0, 3);
                ended[i]     = 1'b0;
            end
            steps = 0;
            live  = 1'b1;
            while (live && steps < 40 && records_sent < rand_start + 120)
            begin
                // refill every advanced head, or mark its stream exhausted
                for (int i = 0; i < n_eff; i++)
                begin
                    if (merge_sb.head_valid[i] || ended[i])
                        continue;
                    if (remaining[i] > 0)
                    begin
                        load_head(i, next_key[i], $urandom, 1'b1);
                        next_key[i] += $urandom_range(0, 3);
                        remaining[i]--;
                    end
                    else
                    begin
                        load_head(i, {$urandom, $urandom}, $urandom, 1'b0);
                        ended[i] = 1'b1;
                    end
                end
                case ($urandom_range(0, 9))
                    0: load_head($urandom_range(0, 63), {$urandom, $urandom}, $urandom,
                                 1'($urandom));
                    1: merge_step();
                    default: ;
                endcase
                live = 1'b0;
                for (int i = 0; i < n_eff; i++)
                    if (merge_sb.head_valid[i])
                        live = 1'b1;
                merge_step();
                if (phase == 2 && steps == 1)
                    drain();
                steps++;
            end
            phase++;
        end

        drain();
        repeat (2 * MAX_SAMPLES_DEF + 12) @(posedge clk);
        if (merge_sb.errors == 0 && merge_sb.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/kmsc_pkg.sv
rtl/kmsc_head_mem.sv
rtl/kmsc_scan.sv
rtl/kmsc_out_reg.sv
rtl/kway_merge_sample_count_filter.sv
tb/sv/tb_top.sv
